/* rtl/core/svipf_pkg.sv */
// ----------------------------------------------------------------------------
// Servo instruction packet framer package
// Command codes, packet byte constants and fixed-point constants for the
// goal position mapping.
// ----------------------------------------------------------------------------
package svipf_pkg;

    typedef enum logic [2:0] {
        CMD_SPEED     = 3'd0,
        CMD_POSITION  = 3'd1,
        CMD_REG_POS   = 3'd2,
        CMD_ACTION    = 3'd3,
        CMD_READ_POS  = 3'd4
    } t_cmd;

    typedef logic [7:0] t_byte;
    typedef logic [3:0] t_len;

    localparam int unsigned PKT_MAX = 9;

    localparam t_byte PKT_HEADER     = 8'hFF;
    localparam t_byte INS_READ       = 8'h02;
    localparam t_byte INS_WRITE      = 8'h03;
    localparam t_byte INS_REG_WRITE  = 8'h04;
    localparam t_byte INS_ACTION     = 8'h05;
    localparam t_byte REG_GOAL_POS   = 8'h1E;
    localparam t_byte REG_MOVE_SPEED = 8'h20;
    localparam t_byte LEN_WRITE      = 8'h05;
    localparam t_byte LEN_ACTION     = 8'h02;
    localparam t_byte LEN_READ       = 8'h04;
    localparam t_byte READ_COUNT     = 8'h02;

    localparam t_len FRAME_WRITE  = 4'd9;
    localparam t_len FRAME_ACTION = 4'd6;
    localparam t_len FRAME_READ   = 4'd8;

    // +-150 degrees in 1/16 degree
    localparam logic signed [12:0] ANGLE_LIMIT = 13'sd2400;
    // 1023/4800 = 341/1600 = (341/64)/25
    localparam logic [8:0]  POS_MUL   = 9'd341;
    // ceil(2^20/25), exact for 15-bit dividends
    localparam logic [15:0] RECIP_25  = 16'd41944;

endpackage

/* rtl/core/servo_instruction_packet_framer.sv */
// ----------------------------------------------------------------------------
// Servo instruction packet framer
// Turns one servo command into the bytes of its instruction packet,
// FF FF id length instruction parameters checksum, one byte per cycle.
// ----------------------------------------------------------------------------
// A command is taken when i_start is high and o_busy is low. Its packet leaves
// one byte per cycle on o_tx_byte with o_strobe high, o_last_byte marking the
// checksum; the receiver must take every byte as it comes. The first byte
// leaves after the input register, the position multiply register, the
// packet register and the serialiser. A packet holds 9 bytes for speed,
// position and registered position commands, 6 for action and 8 for read;
// commands 5 to 7 produce nothing. The byte serialiser sets the rate: while
// commands keep coming, packets follow each other with no gap, and a new
// command is taken while earlier ones are still in the later stages.
module servo_instruction_packet_framer
    import svipf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [2:0]         i_command,
    input  logic [7:0]         i_servo_id,
    input  logic [15:0]        i_speed_value,
    input  logic signed [12:0] i_angle,
    output logic               o_strobe,
    output logic [7:0]         o_tx_byte,
    output logic               o_last_byte
);

    // input stage
    logic               r_in_vld;
    logic [2:0]         r_in_cmd;
    logic [7:0]         r_in_id;
    logic [15:0]        r_in_speed;
    logic signed [12:0] r_in_angle;

    // multiply stage
    logic               r_mid_vld;
    t_cmd               r_mid_cmd;
    logic [7:0]         r_mid_id;
    logic [15:0]        r_mid_speed;
    logic [20:0]        r_mid_x;

    // packet stage
    logic               r_pk_vld;
    t_byte              r_pk_byte [PKT_MAX];
    t_len               r_pk_len;

    // serialiser
    logic               r_ser_act;
    t_byte              r_ser_buf [PKT_MAX];
    t_len               r_ser_left;

    logic               ser_last;
    logic               ser_load;
    logic               pk_free;
    logic               mid_free;
    logic               mid_move;
    logic               in_free;
    logic               in_move;
    logic               accept;
    logic               cmd_ok;

    logic signed [12:0] ang_sat;
    logic [12:0]        ang_off;
    logic [20:0]        n_mid_x;
    logic [14:0]        pos_y;
    logic [30:0]        pos_prod;
    logic [9:0]         pos;
    t_byte              par_lo;
    t_byte              par_hi;
    t_byte              csum;
    t_byte              n_pk_byte [PKT_MAX];
    t_len               n_pk_len;

    // ------------------------------------------------------------------
    // Flow control: each stage advances when the next one frees up
    // ------------------------------------------------------------------
    assign ser_last = r_ser_act && (r_ser_left == t_len'(1));
    assign ser_load = r_pk_vld && (!r_ser_act || ser_last);
    assign pk_free  = !r_pk_vld || ser_load;
    assign mid_move = r_mid_vld && pk_free;
    assign mid_free = !r_mid_vld || pk_free;
    assign in_move  = r_in_vld && mid_free;
    assign in_free  = !r_in_vld || mid_free;
    assign o_busy   = !in_free;
    assign accept   = i_start && in_free;
    assign cmd_ok   = (r_in_cmd <= CMD_READ_POS);

    // ------------------------------------------------------------------
    // Input stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (in_move) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_cmd   <= i_command;
            r_in_id    <= i_servo_id;
            r_in_speed <= i_speed_value;
            r_in_angle <= i_angle;
        end
    end

    // clamp to +-150 degrees, offset by +150 degrees and scale by 341
    always_comb begin
        priority if (r_in_angle > ANGLE_LIMIT) begin
            ang_sat = ANGLE_LIMIT;
        end else if (r_in_angle < -ANGLE_LIMIT) begin
            ang_sat = -ANGLE_LIMIT;
        end else begin
            ang_sat = r_in_angle;
        end
        ang_off = 13'(ang_sat + ANGLE_LIMIT);
        n_mid_x = 21'(22'(ang_off) * 22'(POS_MUL));
    end

    // ------------------------------------------------------------------
    // Multiply stage; unknown commands drop here
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid_vld <= 1'b0;
        end else if (in_move) begin
            r_mid_vld <= cmd_ok;
        end else if (mid_move) begin
            r_mid_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_move) begin
            r_mid_cmd   <= t_cmd'(r_in_cmd);
            r_mid_id    <= r_in_id;
            r_mid_speed <= r_in_speed;
            r_mid_x     <= n_mid_x;
        end
    end

    // divide by 64, then by 25 through the reciprocal
    assign pos_y    = r_mid_x[20:6];
    assign pos_prod = 31'(pos_y) * 31'(RECIP_25);
    assign pos      = pos_prod[29:20];

    always_comb begin
        for (int i = 0; i < PKT_MAX; i++) begin
            n_pk_byte[i] = PKT_HEADER;
        end
        n_pk_byte[2] = r_mid_id;
        par_lo       = 8'h00;
        par_hi       = 8'h00;
        csum         = 8'h00;
        n_pk_len     = FRAME_WRITE;
        unique case (r_mid_cmd)
            CMD_SPEED, CMD_POSITION, CMD_REG_POS: begin
                if (r_mid_cmd == CMD_SPEED) begin
                    par_lo = r_mid_speed[7:0];
                    par_hi = r_mid_speed[15:8];
                end else begin
                    par_lo = pos[7:0];
                    par_hi = {6'b0, pos[9:8]};
                end
                n_pk_byte[3] = LEN_WRITE;
                n_pk_byte[4] = (r_mid_cmd == CMD_REG_POS) ? INS_REG_WRITE : INS_WRITE;
                n_pk_byte[5] = (r_mid_cmd == CMD_SPEED) ? REG_MOVE_SPEED : REG_GOAL_POS;
                n_pk_byte[6] = par_lo;
                n_pk_byte[7] = par_hi;
                csum = r_mid_id + n_pk_byte[3] + n_pk_byte[4] + n_pk_byte[5]
                     + par_lo + par_hi;
                n_pk_byte[8] = ~csum;
                n_pk_len     = FRAME_WRITE;
            end
            CMD_ACTION: begin
                n_pk_byte[3] = LEN_ACTION;
                n_pk_byte[4] = INS_ACTION;
                csum = r_mid_id + LEN_ACTION + INS_ACTION;
                n_pk_byte[5] = ~csum;
                n_pk_len     = FRAME_ACTION;
            end
            CMD_READ_POS: begin
                n_pk_byte[3] = LEN_READ;
                n_pk_byte[4] = INS_READ;
                n_pk_byte[5] = REG_GOAL_POS;
                n_pk_byte[6] = READ_COUNT;
                csum = r_mid_id + LEN_READ + INS_READ + REG_GOAL_POS + READ_COUNT;
                n_pk_byte[7] = ~csum;
                n_pk_len     = FRAME_READ;
            end
            default: begin
                n_pk_len = FRAME_WRITE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Packet stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pk_vld <= 1'b0;
        end else if (mid_move) begin
            r_pk_vld <= 1'b1;
        end else if (ser_load) begin
            r_pk_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mid_move) begin
            r_pk_byte <= n_pk_byte;
            r_pk_len  <= n_pk_len;
        end
    end

    // ------------------------------------------------------------------
    // Serialiser: shift one byte out per cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_act  <= 1'b0;
            r_ser_left <= '0;
        end else if (ser_load) begin
            r_ser_act  <= 1'b1;
            r_ser_left <= r_pk_len;
        end else if (r_ser_act) begin
            r_ser_act  <= !ser_last;
            r_ser_left <= r_ser_left - t_len'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ser_load) begin
            r_ser_buf <= r_pk_byte;
        end else if (r_ser_act) begin
            for (int i = 0; i < PKT_MAX - 1; i++) begin
                r_ser_buf[i] <= r_ser_buf[i + 1];
            end
        end
    end

    assign o_strobe    = r_ser_act;
    assign o_tx_byte   = r_ser_buf[0];
    assign o_last_byte = ser_last;

`ifndef ASSERT_OFF
    // every packet opens with the header byte
    a_header_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_strobe) |-> o_tx_byte == PKT_HEADER)
        else $error("packet does not open with header byte");

    // bytes of one packet leave without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_byte |=> o_strobe)
        else $error("gap inside a packet");

    // a packet waiting at the serialiser goes out straight after the checksum
    a_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_byte && r_pk_vld |=> o_strobe && o_tx_byte == PKT_HEADER)
        else $error("queued packet not sent after previous checksum");

    // an empty input register never reports busy
    a_busy_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_vld |-> !o_busy)
        else $error("busy with empty input register");
`endif

endmodule

/* test/servo_instruction_packet_framer_test.sv */
// ----------------------------------------------------------------------------
// Servo instruction packet framer testbench
// Sends servo commands through the start/busy handshake and frames each
// command into its expected byte sequence: header, id, length, instruction,
// parameters and inverted checksum. Every strobed byte is compared with the
// oldest expected byte. Directed cases cover field extremes, every command,
// angle saturation, unknown commands and ignored fields. Random traffic
// follows, with random gaps between requests and stretches without gaps.
// ----------------------------------------------------------------------------
module servo_instruction_packet_framer_test
    import svipf_pkg::*;
();

    localparam logic [2:0] CMD_FIRST_UNKNOWN = 3'd5;
    localparam logic [2:0] CMD_LAST_UNKNOWN  = 3'd7;
    localparam int         ANGLE_BOUND       = 2400;
    localparam int         POS_SCALE         = 1023;
    localparam int         POS_SPAN          = 4800;
    localparam int         RANDOM_COMMANDS   = 348;
    localparam int         SETTLE_CYCLES     = 20;
    localparam int         CYCLE_LIMIT       = 200000;

    typedef struct packed {
        t_byte data;
        logic  last;
    } t_packet_byte;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    logic [2:0]         i_command;
    logic [7:0]         i_servo_id;
    logic [15:0]        i_speed_value;
    logic signed [12:0] i_angle;
    logic               o_strobe;
    logic [7:0]         o_tx_byte;
    logic               o_last_byte;

    t_packet_byte pending_bytes[$];
    int           error_count;
    int           requests_sent;
    int           unknown_sent;
    int           bytes_checked;
    int           cycle_count;
    bit           no_gaps;

    servo_instruction_packet_framer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_command     (i_command),
        .i_servo_id    (i_servo_id),
        .i_speed_value (i_speed_value),
        .i_angle       (i_angle),
        .o_strobe      (o_strobe),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d bytes still pending", $time, pending_bytes.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Servo position from a signed angle in 1/16 degree, saturated at +-150 degrees
    function automatic int angle_to_pos(input logic signed [12:0] angle);
        int a;
        a = angle;
        if (a > ANGLE_BOUND)
            a = ANGLE_BOUND;
        if (a < -ANGLE_BOUND)
            a = -ANGLE_BOUND;
        return ((a + ANGLE_BOUND) * POS_SCALE) / POS_SPAN;
    endfunction

    // Build the instruction packet for one command and queue its bytes
    function automatic void frame_packet(input logic [2:0] cmd, input t_byte id,
                                         input logic [15:0] speed,
                                         input logic signed [12:0] angle);
        t_byte        pkt [PKT_MAX];
        int           len;
        int           sum;
        int           pos;
        t_packet_byte entry;
        pkt[0] = PKT_HEADER;
        pkt[1] = PKT_HEADER;
        pkt[2] = id;
        pos = angle_to_pos(angle);
        case (cmd)
            CMD_SPEED: begin
                pkt[3] = LEN_WRITE;
                pkt[4] = INS_WRITE;
                pkt[5] = REG_MOVE_SPEED;
                pkt[6] = speed[7:0];
                pkt[7] = speed[15:8];
                len = FRAME_WRITE;
            end
            CMD_POSITION, CMD_REG_POS: begin
                pkt[3] = LEN_WRITE;
                pkt[4] = (cmd == CMD_POSITION) ? INS_WRITE : INS_REG_WRITE;
                pkt[5] = REG_GOAL_POS;
                pkt[6] = t_byte'(pos);
                pkt[7] = t_byte'(pos >> 8);
                len = FRAME_WRITE;
            end
            CMD_ACTION: begin
                pkt[3] = LEN_ACTION;
                pkt[4] = INS_ACTION;
                len = FRAME_ACTION;
            end
            CMD_READ_POS: begin
                pkt[3] = LEN_READ;
                pkt[4] = INS_READ;
                pkt[5] = REG_GOAL_POS;
                pkt[6] = READ_COUNT;
                len = FRAME_READ;
            end
            default: return;
        endcase
        sum = 0;
        for (int i = 2; i < len - 1; i++)
            sum += pkt[i];
        pkt[len - 1] = t_byte'(~sum);
        for (int i = 0; i < len; i++) begin
            entry.data = pkt[i];
            entry.last = (i == len - 1);
            pending_bytes.push_back(entry);
        end
    endfunction

    // Called at a falling edge; returns at a falling edge after the idle gap
    task automatic send_command(input logic [2:0] cmd, input t_byte id,
                                input logic [15:0] speed,
                                input logic signed [12:0] angle);
        int gap;
        i_command     = cmd;
        i_servo_id    = id;
        i_speed_value = speed;
        i_angle       = angle;
        i_start       = 1'b1;
        do
            @(posedge i_clk);
        while (o_busy);
        frame_packet(cmd, id, speed, angle);
        requests_sent++;
        if (cmd >= CMD_FIRST_UNKNOWN)
            unknown_sent++;
        @(negedge i_clk);
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        // hold start high when the next request follows straight on
        if (gap != 0) begin
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : check_bytes
        t_packet_byte want;
        if (i_rst_n && o_strobe) begin
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                         $time, o_tx_byte, o_last_byte);
                error_count++;
            end else begin
                want = pending_bytes.pop_front();
                if (o_tx_byte !== want.data) begin
                    $display("%0t: tx_byte mismatch, expected %02h, actual %02h",
                             $time, want.data, o_tx_byte);
                    error_count++;
                end
                if (o_last_byte !== want.last) begin
                    $display("%0t: last_byte mismatch, expected %0b, actual %0b",
                             $time, want.last, o_last_byte);
                    error_count++;
                end
            end
        end
    end

    task automatic test_field_extremes();
        send_command(CMD_SPEED, 8'h00, 16'h0000, 13'sd0);
        send_command(CMD_SPEED, 8'hFF, 16'hFFFF, 13'sd0);
        send_command(CMD_SPEED, 8'hAA, 16'h00FF, -13'sd1);
        send_command(CMD_SPEED, 8'h55, 16'hFF00, 13'sd4095);
    endtask

    task automatic test_every_command();
        send_command(CMD_SPEED,    8'h01, 16'h1234, 13'sd100);
        send_command(CMD_POSITION, 8'h02, 16'h0000, 13'sd1200);
        send_command(CMD_REG_POS,  8'hFE, 16'h0000, -13'sd1200);
        send_command(CMD_ACTION,   8'hFE, 16'h0000, 13'sd0);
        send_command(CMD_READ_POS, 8'h03, 16'h0000, 13'sd0);
    endtask

    task automatic test_angle_saturation();
        send_command(CMD_POSITION, 8'h10, 16'h0000, -13'sd4096);
        send_command(CMD_POSITION, 8'h11, 16'h0000, -13'sd2401);
        send_command(CMD_REG_POS,  8'h12, 16'h0000, -13'sd2400);
        send_command(CMD_POSITION, 8'h13, 16'h0000, -13'sd1);
        send_command(CMD_REG_POS,  8'h14, 16'h0000, 13'sd2399);
        send_command(CMD_POSITION, 8'h15, 16'h0000, 13'sd2400);
        send_command(CMD_REG_POS,  8'h16, 16'h0000, 13'sd2401);
        send_command(CMD_POSITION, 8'h17, 16'h0000, 13'sd4095);
    endtask

    task automatic test_unknown_commands();
        for (logic [3:0] c = CMD_FIRST_UNKNOWN; c <= CMD_LAST_UNKNOWN; c++)
            send_command(c[2:0], 8'h20, 16'hFFFF, -13'sd1);
    endtask

    task automatic test_ignored_fields();
        send_command(CMD_ACTION,   8'h30, 16'hFFFF, 13'sd4095);
        send_command(CMD_READ_POS, 8'h31, 16'hA5A5, -13'sd4096);
    endtask

    task automatic test_random_traffic();
        int         sent;
        logic [2:0] cmd;
        logic signed [12:0] angle;
        sent = 0;
        while (sent < RANDOM_COMMANDS) begin
            if ($urandom_range(0, 39) == 0)
                no_gaps = !no_gaps;
            if ($urandom_range(0, 9) == 0)
                cmd = 3'($urandom_range(CMD_FIRST_UNKNOWN, CMD_LAST_UNKNOWN));
            else
                cmd = 3'($urandom_range(CMD_SPEED, CMD_READ_POS));
            // mostly in range, now and then anywhere in the 13-bit span
            if ($urandom_range(0, 4) == 0)
                angle = 13'($urandom);
            else
                angle = 13'($urandom_range(0, 2 * ANGLE_BOUND) - ANGLE_BOUND);
            send_command(cmd, 8'($urandom), 16'($urandom), angle);
            sent++;
        end
        no_gaps = 1'b0;
    endtask

    task automatic drain_packets();
        i_start = 1'b0;
        while (pending_bytes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_command     = CMD_SPEED;
        i_servo_id    = '0;
        i_speed_value = '0;
        i_angle       = '0;
        error_count   = 0;
        requests_sent = 0;
        unknown_sent  = 0;
        bytes_checked = 0;
        cycle_count   = 0;
        no_gaps       = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_field_extremes();
        test_every_command();
        test_angle_saturation();
        test_unknown_commands();
        test_ignored_fields();
        test_random_traffic();
        drain_packets();

        $display("Covered %0d commands (%0d unknown) and compared %0d packet bytes,",
                 requests_sent, unknown_sent, bytes_checked);
        $display("including angle saturation, ignored fields and back-to-back requests.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/svipf_pkg.sv
rtl/core/servo_instruction_packet_framer.sv
test/servo_instruction_packet_framer_test.sv
